/* hdl/timer_prescaler_period_select_defines.svh */
// Assertion macros for the timer prescaler and period select block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TIMER_PRESCALER_PERIOD_SELECT_DEFINES_SVH
`define TIMER_PRESCALER_PERIOD_SELECT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define TPPS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tpps check failed");

// Next-cycle implication, disabled during reset
`define TPPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tpps check failed");

`else

`define TPPS_ASSERT_SAME(label, clk, rst, ante, cons)
`define TPPS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/tpps_pkg.sv */
// Shared types, codes and tables for the timer prescaler and period select block.
// No dependencies; used by the interfaces and all modules.
package tpps_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned CODE_W  = 3;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned IDX_W   = 3;
   localparam int unsigned SHIFT_W = 4;

   localparam logic [DATA_W-1:0] RESET_BASE_CLOCK = 32'd24000000;

   // Width mode codes
   localparam logic [MODE_W-1:0] MODE_8BIT  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_16BIT = 2'd1;

   // Status codes
   localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_NO_FIT    = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_ZERO_FREQ = 2'd2;

   // Prescaler code DIV1, used for errors and no fit
   localparam logic [CODE_W-1:0] PRESC_DIV1 = 3'd0;

   // Last entry of the prescaler try table
   localparam logic [IDX_W-1:0] TRY_LAST = 3'd6;

   typedef struct packed {
      logic [DATA_W-1:0] compare_value;
      logic [CODE_W-1:0] prescaler_code;
      logic [STAT_W-1:0] status;
   } result_type;

   // Counter maximum per width mode; the unused mode counts as 32 bit
   function automatic logic [DATA_W-1:0] width_max(input logic [MODE_W-1:0] mode);
      logic [DATA_W-1:0] maxv;
      unique case (mode)
         MODE_8BIT:  maxv = 32'h0000_00FF;
         MODE_16BIT: maxv = 32'h0000_FFFF;
         default:    maxv = 32'hFFFF_FFFF;
      endcase
      return maxv;
   endfunction

   // Prescaler shift for each try; DIV32, DIV128 and DIV512 are skipped
   function automatic logic [SHIFT_W-1:0] try_shift(input logic [IDX_W-1:0] idx);
      logic [SHIFT_W-1:0] sh;
      unique case (idx)
         3'd0:    sh = 4'd1;
         3'd1:    sh = 4'd2;
         3'd2:    sh = 4'd3;
         3'd3:    sh = 4'd4;
         3'd4:    sh = 4'd6;
         3'd5:    sh = 4'd8;
         default: sh = 4'd10;
      endcase
      return sh;
   endfunction

endpackage

/* hdl/tpps_if.sv */
// Valid/ready channel interfaces for request and response transactions.
// Depends on tpps_pkg for field widths.
interface tpps_req_if;
   logic                           valid;
   logic                           ready;
   logic [tpps_pkg::DATA_W-1:0]    target_frequency;
   logic [tpps_pkg::MODE_W-1:0]    width_mode;

   modport source (output valid, target_frequency, width_mode, input ready);
   modport sink   (input valid, target_frequency, width_mode, output ready);
endinterface

interface tpps_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tpps_pkg::DATA_W-1:0]    compare_value;
   logic [tpps_pkg::CODE_W-1:0]    prescaler_code;
   logic [tpps_pkg::STAT_W-1:0]    status;

   modport source (output valid, compare_value, prescaler_code, status, input ready);
   modport sink   (input valid, compare_value, prescaler_code, status, output ready);
endinterface

/* hdl/timer_prescaler_period_select.sv */
// Top level: timer prescaler and period compare selection.
// Depends on tpps_pkg, tpps_if, tpps_divider, tpps_search and the defines header.
//
//   channel | dir | fields                                      | handshake
//   req     | in  | target_frequency[31:0], width_mode[1:0]     | valid/ready
//   rsp     | out | compare_value[31:0], prescaler_code[2:0],   | valid/ready
//           |     | status[1:0]                                 |
//   csr     | in  | csr_wdata[31:0] = base clock in Hz          | csr_we
//
// A transaction passes from accept through the bit-serial divider and then the
// prescaler search before response valid. A zero frequency skips both and goes
// straight to the response. One transaction is in flight at a time; req.ready is
// low until the response is taken, and rsp.ready stalls hold it.
// Reset is synchronous; the base clock register resets to 24 MHz.
`include "timer_prescaler_period_select_defines.svh"

module timer_prescaler_period_select (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [tpps_pkg::DATA_W-1:0] csr_wdata,
   tpps_req_if.sink                    req_bus,
   tpps_rsp_if.source                  rsp_bus
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SEARCH,
      ST_RESPOND
   } state_type;

   state_type                   state_ff;
   logic [tpps_pkg::DATA_W-1:0] base_clock_ff;
   logic [tpps_pkg::MODE_W-1:0] mode_ff;
   tpps_pkg::result_type        rsp_ff;
   logic                        req_accept;
   logic                        zero_freq;
   logic                        div_start;
   logic                        div_done;
   logic [tpps_pkg::DATA_W-1:0] div_quotient;
   logic                        search_done;
   tpps_pkg::result_type        search_result;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign zero_freq     = (req_bus.target_frequency == '0);
   assign div_start     = req_accept && !zero_freq;

   // Base clock configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         base_clock_ff <= tpps_pkg::RESET_BASE_CLOCK;
      end else if (csr_we) begin
         base_clock_ff <= csr_wdata;
      end
   end

   // Ratio = base clock / frequency
   tpps_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (base_clock_ff),
      .divisor  (req_bus.target_frequency),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Prescaler search over the ratio
   tpps_search u_search (
      .clock      (clock),
      .reset      (reset),
      .start      (div_done),
      .ratio      (div_quotient),
      .width_mode (mode_ff),
      .done       (search_done),
      .result     (search_result)
   );

   // Sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  mode_ff <= req_bus.width_mode;
                  if (zero_freq) begin
                     rsp_ff.compare_value  <= '0;
                     rsp_ff.prescaler_code <= tpps_pkg::PRESC_DIV1;
                     rsp_ff.status         <= tpps_pkg::STATUS_ZERO_FREQ;
                     state_ff              <= ST_RESPOND;
                  end else begin
                     state_ff <= ST_DIVIDE;
                  end
               end
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  state_ff <= ST_SEARCH;
               end
            end
            ST_SEARCH: begin
               if (search_done) begin
                  rsp_ff   <= search_result;
                  state_ff <= ST_RESPOND;
               end
            end
            ST_RESPOND: begin
               if (rsp_bus.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid          = (state_ff == ST_RESPOND);
   assign rsp_bus.compare_value  = rsp_ff.compare_value;
   assign rsp_bus.prescaler_code = rsp_ff.prescaler_code;
   assign rsp_bus.status         = rsp_ff.status;

   // Checks
   `TPPS_ASSERT_SAME(a_div_done_in_divide, clock, reset, div_done, state_ff == ST_DIVIDE)
   `TPPS_ASSERT_SAME(a_search_done_in_search, clock, reset, search_done, state_ff == ST_SEARCH)
   `TPPS_ASSERT_NEXT(a_accept_drops_ready, clock, reset, req_accept, !req_bus.ready)
   `TPPS_ASSERT_SAME(a_zero_freq_result, clock, reset,
      rsp_bus.valid && rsp_bus.status == tpps_pkg::STATUS_ZERO_FREQ,
      rsp_bus.compare_value == '0 && rsp_bus.prescaler_code == tpps_pkg::PRESC_DIV1)

endmodule

/* hdl/tpps_divider.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on tpps_pkg for the data width.
module tpps_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tpps_pkg::DATA_W-1:0] dividend,
   input  logic [tpps_pkg::DATA_W-1:0] divisor,
   output logic                        done,
   output logic [tpps_pkg::DATA_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(tpps_pkg::DATA_W);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [tpps_pkg::DATA_W-1:0] rem_ff, rem_in;
   logic [tpps_pkg::DATA_W-1:0] quo_ff, quo_in;
   logic [tpps_pkg::DATA_W-1:0] div_ff, div_in;
   logic [tpps_pkg::DATA_W:0]   trial;
   logic [tpps_pkg::DATA_W:0]   diff;
   logic                        fits;

   // Shift in the next dividend bit and trial subtract
   assign trial = {rem_ff, quo_ff[tpps_pkg::DATA_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '1;
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[tpps_pkg::DATA_W-1:0] : trial[tpps_pkg::DATA_W-1:0];
         quo_in   = {quo_ff[tpps_pkg::DATA_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      div_ff   <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hdl/tpps_search.sv */
// Prescaler search: one shift, subtract and compare per cycle over the try table.
// Depends on tpps_pkg for the try table, width limits and result type.
module tpps_search (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tpps_pkg::DATA_W-1:0] ratio,
   input  logic [tpps_pkg::MODE_W-1:0] width_mode,
   output logic                        done,
   output tpps_pkg::result_type        result
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [tpps_pkg::IDX_W-1:0]  idx_ff, idx_in;
   logic [tpps_pkg::DATA_W-1:0] ratio_ff, ratio_in;
   logic [tpps_pkg::DATA_W-1:0] maxv_ff, maxv_in;
   tpps_pkg::result_type        result_ff, result_in;
   logic [tpps_pkg::DATA_W-1:0] cmp;

   // Shared unit: compare = (ratio >> shift) - 1, wrapping
   assign cmp = (ratio_ff >> tpps_pkg::try_shift(idx_ff)) - 1'b1;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      idx_in    = idx_ff;
      ratio_in  = ratio_ff;
      maxv_in   = maxv_ff;
      result_in = result_ff;
      if (start) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         ratio_in = ratio;
         maxv_in  = tpps_pkg::width_max(width_mode);
      end else if (busy_ff) begin
         result_in.compare_value = cmp;
         priority if (cmp < maxv_ff) begin
            result_in.prescaler_code = idx_ff + 1'b1;
            result_in.status         = tpps_pkg::STATUS_OK;
            busy_in                  = 1'b0;
            done_in                  = 1'b1;
         end else if (idx_ff == tpps_pkg::TRY_LAST) begin
            result_in.prescaler_code = tpps_pkg::PRESC_DIV1;
            result_in.status         = tpps_pkg::STATUS_NO_FIT;
            busy_in                  = 1'b0;
            done_in                  = 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      idx_ff    <= idx_in;
      ratio_ff  <= ratio_in;
      maxv_ff   <= maxv_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

/* verif/tpps_checker.sv */
// Checker for the timer prescaler and period select block: predicts every response
// from the request channel and the base clock register and compares it in order.
// Depends on tpps_pkg and the request/response interfaces in tpps_if.
module tpps_checker
   import tpps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [DATA_W-1:0] csr_wdata,
   tpps_req_if               req_bus,
   tpps_rsp_if               rsp_bus,
   output int unsigned       fail_count,
   output int unsigned       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Prescaler codes that a successful search can select
   localparam logic [CODE_W-1:0] PRESC_DIV2    = 3'd1;
   localparam logic [CODE_W-1:0] PRESC_DIV4    = 3'd2;
   localparam logic [CODE_W-1:0] PRESC_DIV8    = 3'd3;
   localparam logic [CODE_W-1:0] PRESC_DIV16   = 3'd4;
   localparam logic [CODE_W-1:0] PRESC_DIV64   = 3'd5;
   localparam logic [CODE_W-1:0] PRESC_DIV256  = 3'd6;
   localparam logic [CODE_W-1:0] PRESC_DIV1024 = 3'd7;

   localparam int unsigned SEARCH_STEPS = 7;

   // Search order, entry 0 first; DIV32, DIV128 and DIV512 are never tried
   localparam logic [SEARCH_STEPS-1:0][3:0] STEP_SHIFT =
      {4'd10, 4'd8, 4'd6, 4'd4, 4'd3, 4'd2, 4'd1};
   localparam logic [SEARCH_STEPS-1:0][CODE_W-1:0] STEP_CODE =
      {PRESC_DIV1024, PRESC_DIV256, PRESC_DIV64, PRESC_DIV16,
       PRESC_DIV8, PRESC_DIV4, PRESC_DIV2};

   logic [DATA_W-1:0] timer_clock;
   result_type        settings_due[$];

   // Expected compare value, prescaler and status for one request
   function automatic result_type predict_period(input logic [DATA_W-1:0] base,
                                                 input logic [DATA_W-1:0] freq,
                                                 input logic [MODE_W-1:0] mode);
      result_type        r;
      logic [DATA_W-1:0] ratio;
      logic [DATA_W-1:0] ceiling;
      logic [DATA_W-1:0] cmp;
      r.compare_value  = '0;
      r.prescaler_code = PRESC_DIV1;
      r.status         = STATUS_ZERO_FREQ;
      if (freq == '0) begin
         return r;
      end
      case (mode)
         MODE_8BIT:  ceiling = 32'h0000_00FF;
         MODE_16BIT: ceiling = 32'h0000_FFFF;
         default:    ceiling = 32'hFFFF_FFFF;
      endcase
      ratio    = base / freq;
      r.status = STATUS_NO_FIT;
      for (int k = 0; k < SEARCH_STEPS; k++) begin
         // quotient of zero wraps to all ones and never fits
         cmp             = (ratio >> STEP_SHIFT[k]) - 32'd1;
         r.compare_value = cmp;
         if (cmp < ceiling) begin
            r.prescaler_code = STEP_CODE[k];
            r.status         = STATUS_OK;
            break;
         end
      end
      return r;
   endfunction

   // Track the register, check responses, then queue the new prediction
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         timer_clock <= RESET_BASE_CLOCK;
         fail_count  <= 0;
         pending     <= 0;
         settings_due.delete();
      end else begin
         if (csr_we) begin
            timer_clock <= csr_wdata;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.compare_value  = rsp_bus.compare_value;
            got.prescaler_code = rsp_bus.prescaler_code;
            got.status         = rsp_bus.status;
            if (settings_due.size() == 0) begin
               $display("%0t: response with nothing outstanding: compare %h presc %0d status %0d",
                        $time, got.compare_value, got.prescaler_code, got.status);
               fail_count <= fail_count + 1;
            end else begin
               want = settings_due.pop_front();
               if (got.compare_value !== want.compare_value ||
                   got.prescaler_code !== want.prescaler_code ||
                   got.status !== want.status) begin
                  $display("%0t: mismatch: expected compare %h presc %0d status %0d",
                           $time, want.compare_value, want.prescaler_code, want.status);
                  $display("%0t:           actual   compare %h presc %0d status %0d",
                           $time, got.compare_value, got.prescaler_code, got.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            settings_due.push_back(predict_period(timer_clock, req_bus.target_frequency,
                                                  req_bus.width_mode));
         end
         pending <= settings_due.size();
      end
   end

endmodule

/* verif/testbench.sv */
// Top of the timer prescaler and period select testbench: clock, reset, stimulus,
// base clock writes and the verdict. Depends on tpps_pkg, tpps_if, tpps_checker, the RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tpps_pkg::*;

   localparam logic [MODE_W-1:0] MODE_32BIT  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   localparam int unsigned PHASE_ITEMS  = 115;
   localparam int unsigned SETTLE_WAIT  = 45;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [DATA_W-1:0] csr_wdata;
   int unsigned       fail_count;
   int unsigned       pending;
   int unsigned       cycles;
   logic [DATA_W-1:0] base_now;
   logic              send_idle;
   logic              recv_idle;

   tpps_req_if req_bus();
   tpps_rsp_if rsp_bus();

   timer_prescaler_period_select u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   tpps_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // One request transaction; valid stays up when no gap follows
   task automatic send_request(input logic [DATA_W-1:0] freq, input logic [MODE_W-1:0] mode);
      int unsigned gap;
      gap = send_idle ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.target_frequency <= freq;
      req_bus.width_mode       <= mode;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Stop sending and wait until every outstanding response has come back
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_base(input logic [DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      base_now  = value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Random request, biased toward ratios that land near the search boundaries
   task automatic random_request();
      logic [DATA_W-1:0] freq;
      logic [DATA_W-1:0] ratio;
      logic [DATA_W-1:0] span;
      logic [MODE_W-1:0] mode;
      int unsigned       pick;
      mode = MODE_W'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         freq = '0;
      end else if (pick < 55) begin
         ratio = $urandom >> $urandom_range(0, 31);
         if (ratio == '0) ratio = 32'd1;
         freq = base_now / ratio;
         if (freq == '0) freq = 32'd1;
      end else if (pick < 75) begin
         if (mode == MODE_8BIT) begin
            span = 32'd256;
         end else if (mode == MODE_16BIT) begin
            span = 32'd65536;
         end else begin
            span = 32'd1;
         end
         ratio = (span << $urandom_range(0, 10)) + $urandom_range(0, 2) - 32'd1;
         if (ratio == '0) ratio = 32'd1;
         freq = base_now / ratio + $urandom_range(0, 1);
         if (freq == '0) freq = 32'd1;
      end else if (pick < 90) begin
         freq = $urandom;
      end else begin
         freq = $urandom >> $urandom_range(0, 31);
      end
      send_request(freq, mode);
   endtask

   // Response side: random stall before each transaction
   initial begin
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = recv_idle ? $urandom_range(0, 19) : 0;
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Stimulus and verdict
   initial begin
      logic [DATA_W-1:0] bases[$];
      reset                    <= 1'b1;
      csr_we                   <= 1'b0;
      csr_wdata                <= '0;
      req_bus.valid            <= 1'b0;
      req_bus.target_frequency <= '0;
      req_bus.width_mode       <= MODE_8BIT;
      base_now  = RESET_BASE_CLOCK;
      send_idle = 1'b1;
      recv_idle = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero frequency, wrap, every prescaler, width boundaries
      send_request(32'd0, MODE_8BIT);
      send_request(32'd0, MODE_UNUSED);
      send_request(32'hFFFF_FFFF, MODE_32BIT);
      send_request(32'd1, MODE_8BIT);
      send_request(32'd1, MODE_16BIT);
      send_request(32'd1, MODE_32BIT);
      send_request(32'd1, MODE_UNUSED);
      send_request(32'd46875, MODE_8BIT);      // compare equals the 8 bit max
      send_request(32'd47000, MODE_8BIT);
      send_request(32'd12000000, MODE_8BIT);
      send_request(32'd12000001, MODE_16BIT);  // quotient zero at every shift
      send_request(32'd24000000, MODE_32BIT);
      send_request(32'd100, MODE_16BIT);
      send_request(32'd1000, MODE_8BIT);
      send_request(32'd25000, MODE_8BIT);
      send_request(32'd12000, MODE_8BIT);
      send_request(32'd6000, MODE_8BIT);
      send_request(32'd3000, MODE_8BIT);
      send_request(32'd200, MODE_8BIT);
      send_request(32'h8000_0000, MODE_16BIT);
      send_request(32'h5555_5555, MODE_UNUSED);
      send_request(32'hAAAA_AAAA, MODE_8BIT);
      drain();

      // Random phases, each under its own base clock; zero base gives no fit for every nonzero frequency
      bases = '{RESET_BASE_CLOCK, 32'd16777216, 32'hFFFF_FFFF, 32'd1, 32'd0,
                $urandom, 32'd48000000, $urandom_range(1000, 100000000),
                RESET_BASE_CLOCK};
      foreach (bases[p]) begin
         if (p != 0) begin
            write_base(bases[p]);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) begin
               send_idle = (p == 0 && n == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
               recv_idle = (p == 0 && n == 0) ? 1'b0 : ($urandom_range(0, 2) != 0);
            end
            random_request();
         end
         drain();
      end

      repeat (SETTLE_WAIT) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/tpps_pkg.sv
hdl/tpps_if.sv
hdl/tpps_divider.sv
hdl/tpps_search.sv
hdl/timer_prescaler_period_select.sv
verif/tpps_checker.sv
verif/testbench.sv
